/* rtl/spe_pkg.sv */
// Shared constants and types for the 3x3 edge-magnitude filter.
// No dependencies; every other file in rtl/ except spe_ram imports this package.
package spe_pkg;

  // Line store geometry
  localparam int MAX_LINE_WIDTH = 1024;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W          = 12;
  localparam int PIX_W          = 8;

  // Configuration register widths and limits
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 12;
  localparam int MIN_DIM      = 3;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 4;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_METHOD = 2'd2;

  // Mask pair select
  localparam logic METHOD_SOBEL   = 1'b0;
  localparam logic METHOD_PREWITT = 1'b1;

  // Datapath widths
  localparam int GRAD_W    = PIX_W + 2;        // |Ix|, |Iy| up to 4*255
  localparam int SQ_W      = 2 * GRAD_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int MAG_W     = 8;
  localparam int ROOT_IN_W = 2 * MAG_W;        // sums at or above 2^16 saturate

  // 3x3 window: [row][column], row 0 oldest line, column 2 newest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] spe_win_t;

  // Sideband that travels with each pixel down the pipe
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } spe_tag_t;

endpackage

/* rtl/spe_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/spe_window.sv */
// Raster counters, line store memory and 3x3 window of the edge filter.
// Depends on spe_pkg and spe_ram.
module spe_window import spe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             accept,
  input  logic             restart,
  input  logic [PIX_W-1:0] pixel,
  input  logic [COL_W-1:0] col_last,
  input  logic [ROW_W-1:0] row_last,
  output spe_win_t         win,
  output logic             win_emit,
  output spe_tag_t         win_tag
);

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               s1_valid_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_emit_r;
  spe_tag_t           s1_tag_r;
  logic [2*PIX_W-1:0] line_q;
  logic [PIX_W-1:0]   top_pix, mid_pix;
  logic               line_we;
  spe_win_t           win_r;
  logic               s2_emit_r;
  spe_tag_t           s2_tag_r;

  // Column / row position of the next beat
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == col_last) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: line store read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && accept) begin
      s1_pix_r      <= pixel;
      s1_col_r      <= col_r;
      s1_emit_r     <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_tag_r.row  <= row_r - 1'b1;
      s1_tag_r.col  <= col_r - 1'b1;
      s1_tag_r.done <= (row_r == row_last) && (col_r == col_last);
    end
  end

  // Both lines share one entry: {older, newer}. Read in stage 0, written
  // back in stage 1. Consecutive beats hit different columns, so the read
  // and the write-back of one cycle never collide.
  assign line_we = adv && s1_valid_r;
  assign top_pix = line_q[2*PIX_W-1:PIX_W];
  assign mid_pix = line_q[PIX_W-1:0];

  spe_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_col_r),
    .wdata ({mid_pix, s1_pix_r}),
    .re    (adv),
    .raddr (col_r),
    .rdata (line_q)
  );

  // Stage 2: window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (line_we) begin
      for (int u = 0; u < 3; u++) begin
        win_r[u][0] <= win_r[u][1];
        win_r[u][1] <= win_r[u][2];
      end
      win_r[0][2] <= top_pix;
      win_r[1][2] <= mid_pix;
      win_r[2][2] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_emit_r <= 1'b0;
    end else if (adv) begin
      s2_emit_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag_r <= s1_tag_r;
    end
  end

  assign win      = win_r;
  assign win_emit = s2_emit_r;
  assign win_tag  = s2_tag_r;

endmodule

/* rtl/spe_grad.sv */
// Sobel / Prewitt gradients of the 3x3 window and their squares.
// Depends on spe_pkg.
module spe_grad import spe_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            method,
  input  spe_win_t        win,
  input  logic            in_emit,
  input  spe_tag_t        in_tag,
  output logic [SQ_W-1:0] sq_x,
  output logic [SQ_W-1:0] sq_y,
  output logic            out_emit,
  output spe_tag_t        out_tag
);

  logic [GRAD_W-1:0] px, nx, py, ny;
  logic [GRAD_W-1:0] ax, ay;
  logic [GRAD_W-1:0] ax_r, ay_r;
  logic              a_emit_r;
  spe_tag_t          a_tag_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r;
  logic              b_emit_r;
  spe_tag_t          b_tag_r;

  // Center tap weight: 2 for Sobel, 1 for Prewitt
  function automatic logic [GRAD_W-1:0] ctr_tap(input logic m, input logic [PIX_W-1:0] p);
    return (m == METHOD_SOBEL) ? GRAD_W'({p, 1'b0}) : GRAD_W'(p);
  endfunction

  // Positive and negative halves of each mask; |I| = |pos - neg|
  always_comb begin
    px = GRAD_W'(win[0][2]) + ctr_tap(method, win[1][2]) + GRAD_W'(win[2][2]);
    nx = GRAD_W'(win[0][0]) + ctr_tap(method, win[1][0]) + GRAD_W'(win[2][0]);
    py = GRAD_W'(win[2][0]) + ctr_tap(method, win[2][1]) + GRAD_W'(win[2][2]);
    ny = GRAD_W'(win[0][0]) + ctr_tap(method, win[0][1]) + GRAD_W'(win[0][2]);
    ax = (px >= nx) ? px - nx : nx - px;
    ay = (py >= ny) ? py - ny : ny - py;
  end

  // Stage A: absolute gradients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_emit_r <= 1'b0;
    end else if (adv) begin
      a_emit_r <= in_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r    <= ax;
      ay_r    <= ay;
      a_tag_r <= in_tag;
    end
  end

  // Stage B: squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_emit_r <= 1'b0;
    end else if (adv) begin
      b_emit_r <= a_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x_r  <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sq_y_r  <= SQ_W'(ay_r) * SQ_W'(ay_r);
      b_tag_r <= a_tag_r;
    end
  end

  assign sq_x     = sq_x_r;
  assign sq_y     = sq_y_r;
  assign out_emit = b_emit_r;
  assign out_tag  = b_tag_r;

endmodule

/* rtl/spe_sqrt.sv */
// Pipelined integer square root of Ix^2 + Iy^2, saturated to 8 bits.
// Depends on spe_pkg. Digit-by-digit restoring method, four root bits a stage.
module spe_sqrt import spe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [SQ_W-1:0]  sq_x,
  input  logic [SQ_W-1:0]  sq_y,
  input  logic             in_emit,
  input  spe_tag_t         in_tag,
  output logic [MAG_W-1:0] mag,
  output logic             out_emit,
  output spe_tag_t         out_tag
);

  localparam int REM_W = MAG_W + 2;
  localparam int STEPS = MAG_W / 2;
  localparam int HALF  = ROOT_IN_W / 2;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] q;
  } spe_root_t;

  logic [SUM_W-1:0]     sum;
  logic                 c_sat_r;
  logic [ROOT_IN_W-1:0] c_x_r;
  logic                 c_emit_r;
  spe_tag_t             c_tag_r;
  spe_root_t            d_st, d_st_r;
  logic [HALF-1:0]      d_lo_r;
  logic                 d_sat_r;
  logic                 d_emit_r;
  spe_tag_t             d_tag_r;
  spe_root_t            e_st;
  logic [MAG_W-1:0]     e_mag_r;
  logic                 e_emit_r;
  spe_tag_t             e_tag_r;

  // One root digit: bring down two radicand bits, try q*4+1
  function automatic spe_root_t root_step(input spe_root_t s, input logic [1:0] pair);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    spe_root_t        r;
    cur   = {s.rem, pair};
    trial = (REM_W+2)'({s.q, 2'b01});
    if (cur >= trial) begin
      r.rem = REM_W'(cur - trial);
      r.q   = {s.q[MAG_W-2:0], 1'b1};
    end else begin
      r.rem = REM_W'(cur);
      r.q   = {s.q[MAG_W-2:0], 1'b0};
    end
    return r;
  endfunction

  assign sum = SUM_W'(sq_x) + SUM_W'(sq_y);

  // Stage C: sum and saturation flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_emit_r <= 1'b0;
    end else if (adv) begin
      c_emit_r <= in_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sat_r <= |sum[SUM_W-1:ROOT_IN_W];
      c_x_r   <= sum[ROOT_IN_W-1:0];
      c_tag_r <= in_tag;
    end
  end

  // Stage D: upper four root bits
  always_comb begin
    d_st = '0;
    for (int i = 0; i < STEPS; i++) begin
      d_st = root_step(d_st, c_x_r[ROOT_IN_W-1-2*i -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_emit_r <= 1'b0;
    end else if (adv) begin
      d_emit_r <= c_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_st_r  <= d_st;
      d_lo_r  <= c_x_r[HALF-1:0];
      d_sat_r <= c_sat_r;
      d_tag_r <= c_tag_r;
    end
  end

  // Stage E: lower four root bits, saturate
  always_comb begin
    e_st = d_st_r;
    for (int i = 0; i < STEPS; i++) begin
      e_st = root_step(e_st, d_lo_r[HALF-1-2*i -: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_emit_r <= 1'b0;
    end else if (adv) begin
      e_emit_r <= d_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mag_r <= d_sat_r ? '1 : e_st.q;
      e_tag_r <= d_tag_r;
    end
  end

  assign mag      = e_mag_r;
  assign out_emit = e_emit_r;
  assign out_tag  = e_tag_r;

endmodule

/* rtl/sobel_prewitt_edge_magnitude.sv */
// Sobel / Prewitt 3x3 edge-magnitude filter: top level with APB registers,
// pipeline control and output skid buffer. Depends on spe_pkg, spe_window,
// spe_grad and spe_sqrt.
//
// Pixels enter in raster order at up to one beat per clock, sustained while
// the sink keeps taking results: the two previous lines live in one 1024 x 16
// RAM (one read and one write port), read at a pixel's column in stage 0 and
// written back from stage 1, so each pixel uses each port exactly once. A
// result for an interior pixel leaves after the beat of the pixel below-right
// of it is accepted and passes the RAM read, window, gradient, square, sum,
// two root stages and the output register. The output has a two-entry buffer;
// in_ready falls only when both entries hold results that the sink has not
// taken, and the whole pipe then holds. The line RAM needs no clearing after
// reset: the first two lines of every frame fill it before any value read
// from it reaches a result. Writing image_width or image_height restarts the
// frame; write registers only when the pipe is empty.
module sobel_prewitt_edge_magnitude import spe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel_value,
  // Result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MAG_W-1:0]      out_magnitude,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col,
  output logic                  out_frame_done,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    spe_tag_t         tag;
  } spe_res_t;

  logic [CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [CFG_HEIGHT_W-1:0] cfg_height_r;
  logic                    cfg_method_r;
  logic                    cfg_wr;
  logic [1:0]              cfg_idx;
  logic                    restart;
  logic [CFG_WIDTH_W-1:0]  width_use;
  logic [CFG_HEIGHT_W-1:0] height_use;
  logic [COL_W-1:0]        col_last;
  logic [ROW_W-1:0]        row_last;
  logic                    adv;
  logic                    accept;
  spe_win_t                win;
  logic                    win_emit;
  spe_tag_t                win_tag;
  logic [SQ_W-1:0]         sq_x, sq_y;
  logic                    sq_emit;
  spe_tag_t                sq_tag;
  logic [MAG_W-1:0]        fin_mag;
  logic                    fin_emit;
  spe_tag_t                fin_tag;
  spe_res_t                fin_res;
  logic                    new_res;
  logic                    take;
  logic                    out_valid_r;
  spe_res_t                out_res_r;
  logic                    skid_valid_r;
  spe_res_t                skid_r;

  // APB register write
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_WIDTH_W'(640);
      cfg_height_r <= CFG_HEIGHT_W'(480);
      cfg_method_r <= METHOD_SOBEL;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  cfg_width_r  <= pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT: cfg_height_r <= pwdata[CFG_HEIGHT_W-1:0];
        REG_METHOD: cfg_method_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // APB register read
  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = APB_DATA_W'(cfg_width_r);
      REG_HEIGHT: prdata = APB_DATA_W'(cfg_height_r);
      REG_METHOD: prdata = APB_DATA_W'(cfg_method_r);
      default:    prdata = '0;
    endcase
  end

  // Frame size in use: width clamped between 3 and the line store, height at least 3
  always_comb begin
    width_use = cfg_width_r;
    if (cfg_width_r < CFG_WIDTH_W'(MIN_DIM)) begin
      width_use = CFG_WIDTH_W'(MIN_DIM);
    end else if (cfg_width_r > CFG_WIDTH_W'(MAX_LINE_WIDTH)) begin
      width_use = CFG_WIDTH_W'(MAX_LINE_WIDTH);
    end
    height_use = cfg_height_r;
    if (cfg_height_r < CFG_HEIGHT_W'(MIN_DIM)) begin
      height_use = CFG_HEIGHT_W'(MIN_DIM);
    end
  end

  assign col_last = COL_W'(width_use - 1'b1);
  assign row_last = ROW_W'(height_use - 1'b1);

  // Pipe moves whenever the skid entry is free
  assign adv      = !skid_valid_r;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  spe_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .accept   (accept),
    .restart  (restart),
    .pixel    (in_pixel_value),
    .col_last (col_last),
    .row_last (row_last),
    .win      (win),
    .win_emit (win_emit),
    .win_tag  (win_tag)
  );

  spe_grad u_grad (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .method   (cfg_method_r),
    .win      (win),
    .in_emit  (win_emit),
    .in_tag   (win_tag),
    .sq_x     (sq_x),
    .sq_y     (sq_y),
    .out_emit (sq_emit),
    .out_tag  (sq_tag)
  );

  spe_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .sq_x     (sq_x),
    .sq_y     (sq_y),
    .in_emit  (sq_emit),
    .in_tag   (sq_tag),
    .mag      (fin_mag),
    .out_emit (fin_emit),
    .out_tag  (fin_tag)
  );

  // Output register plus skid entry
  assign fin_res.mag = fin_mag;
  assign fin_res.tag = fin_tag;
  assign new_res     = adv && fin_emit;
  assign take        = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= new_res;
    end else if (new_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_res_r <= skid_r;
      end
    end else if (!out_valid_r || take) begin
      if (new_res) begin
        out_res_r <= fin_res;
      end
    end else if (new_res) begin
      skid_r <= fin_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_magnitude  = out_res_r.mag;
  assign out_row        = out_res_r.tag.row;
  assign out_col        = out_res_r.tag.col;
  assign out_frame_done = out_res_r.tag.done;

endmodule

/* rtl/spe_checker.sv */
// Port-level checks for the edge-magnitude filter, bound to the top level.
// Depends on spe_pkg and sobel_prewitt_edge_magnitude.
module spe_checker import spe_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [MAG_W-1:0] out_magnitude,
  input logic [ROW_W-1:0] out_row,
  input logic [COL_W-1:0] out_col,
  input logic             out_frame_done
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude) &&
      $stable(out_row) && $stable(out_col) && $stable(out_frame_done))
    else $error("result beat changed while stalled");

  // Input backpressure only when a result is waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  // Backpressure follows a refused result beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("in_ready low without a prior output stall");

  // Results never name a pixel in row 0 or column 0
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row != '0) && (out_col != '0))
    else $error("result for a border pixel");

endmodule

bind sobel_prewitt_edge_magnitude spe_checker u_spe_checker (.*);
